@@ rtl/stream_find_replace_assert.svh @@
// Assertion macros shared by the stream find/replace RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef STREAM_FIND_REPLACE_ASSERT_SVH
`define STREAM_FIND_REPLACE_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define SFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication in the same cycle, checked outside reset.
`define SFR_ASSERT_IMPLY(label, cond, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) \
    else $error(msg);

`endif

@@ rtl/sfr_pkg.sv @@
// Package for the stream find/replace block: sizes, register codes, job types.
// No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int unsigned MaxPattern     = 8;
  localparam int unsigned MaxReplacement = 8;
  localparam int unsigned PatLimit       = (MaxPattern < 8) ? MaxPattern : 8;
  localparam int unsigned RepLimit       = (MaxReplacement < 8) ? MaxReplacement : 8;
  localparam int unsigned WinDepth       = 8;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned WordW          = WinDepth * ByteW;
  localparam int unsigned LenW           = 4;
  localparam int unsigned CntW           = $clog2(WinDepth);
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 64;
  localparam int unsigned JobDepth       = 2;
  localparam int unsigned JobPtrW        = $clog2(JobDepth);
  localparam int unsigned JobCntW        = $clog2(JobDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    RegPatBytes = 2'd0,
    RegPatLen   = 2'd1,
    RegRepBytes = 2'd2,
    RegRepLen   = 2'd3
  } sfr_reg_e;

  // One burst of result bytes caused by a single input byte.
  typedef struct packed {
    logic [WordW-1:0] bytes;  // first result byte in bits 7..0
    logic [CntW-1:0]  nm1;    // number of bytes minus one
    logic             last;   // burst ends the text
  } sfr_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sfr_q_status_t;

  // Zero reads as one, anything above the limit reads as the limit.
  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] v,
                                                input logic [LenW-1:0] lim);
    logic [LenW-1:0] r;
    r = v;
    if (v == '0) begin
      r = LenW'(1);
    end else if (v > lim) begin
      r = lim;
    end
    return r;
  endfunction

endpackage

@@ rtl/sfr_front.sv @@
// Front part: configuration registers, match window and job classification.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_front import sfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 accept_i,
  input  logic [ByteW-1:0]     in_char_i,
  input  logic                 in_last_i,
  output logic                 job_push_o,
  output sfr_job_t             job_o
);

  logic [WordW-1:0] pat_bytes_q;
  logic [LenW-1:0]  pat_len_q;
  logic [WordW-1:0] rep_bytes_q;
  logic [LenW-1:0]  rep_len_q;

  logic [WordW-1:0] win_q, win_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic [WordW-1:0] win_push;
  logic [LenW-1:0]  cnt_push;
  logic [LenW-1:0]  plen, rlen;
  logic [WinDepth-1:0] byte_ok;
  logic             match;
  logic [LenW-1:0]  n_emit;
  logic [LenW-1:0]  n_keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= LenW'(1);
      rep_bytes_q <= '0;
      rep_len_q   <= LenW'(1);
    end else if (cfg_we_i) begin
      unique case (sfr_reg_e'(cfg_idx_i))
        RegPatBytes: pat_bytes_q <= cfg_data_i[WordW-1:0];
        RegPatLen:   pat_len_q   <= cfg_data_i[LenW-1:0];
        RegRepBytes: rep_bytes_q <= cfg_data_i[WordW-1:0];
        RegRepLen:   rep_len_q   <= cfg_data_i[LenW-1:0];
      endcase
    end
  end

  always_comb begin
    plen = clamp_len(pat_len_q, LenW'(PatLimit));
    rlen = clamp_len(rep_len_q, LenW'(RepLimit));

    // Place the new byte behind the pending ones.
    for (int i = 0; i < WinDepth; i++) begin
      win_push[i*ByteW +: ByteW] = (CntW'(i) == cnt_q) ? in_char_i
                                                       : win_q[i*ByteW +: ByteW];
    end
    cnt_push = LenW'(cnt_q) + LenW'(1);

    for (int i = 0; i < WinDepth; i++) begin
      byte_ok[i] = (LenW'(i) >= plen) ||
                   (win_push[i*ByteW +: ByteW] == pat_bytes_q[i*ByteW +: ByteW]);
    end
    match = (cnt_push == plen) && (&byte_ok);

    // Number of oldest window bytes to drop out.
    if (cnt_push > plen) begin
      n_emit = cnt_push - plen + LenW'(1);
    end else if (cnt_push == plen && !match) begin
      n_emit = LenW'(1);
    end else begin
      n_emit = '0;
    end
    if (in_last_i && !match) begin
      n_emit = cnt_push;
    end
    n_keep = match ? '0 : (cnt_push - n_emit);

    win_d = win_push >> {n_emit, 3'b000};
    cnt_d = n_keep[CntW-1:0];

    job_o.bytes = match ? rep_bytes_q : win_push;
    job_o.nm1   = match ? CntW'(rlen - LenW'(1)) : CntW'(n_emit - LenW'(1));
    job_o.last  = in_last_i;
    job_push_o  = accept_i && (match || (n_emit != '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
    end
  end

  // Bytes past the fill count are never compared, so they hold no reset.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_d;
    end
  end

endmodule

@@ rtl/sfr_job_fifo.sv @@
// Short job queue between the front and back parts.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_job_fifo import sfr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfr_job_t      data_i,
  input  logic          pop_i,
  output sfr_job_t      data_o,
  output sfr_q_status_t status_o
);

  sfr_job_t             mem_q [JobDepth];
  logic [JobPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [JobCntW-1:0]   count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + JobCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - JobCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == JobPtrW'(JobDepth - 1)) ? '0 : wr_ptr_q + JobPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == JobPtrW'(JobDepth - 1)) ? '0 : rd_ptr_q + JobPtrW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == JobCntW'(JobDepth));
  assign status_o.empty = (count_q == '0);

endmodule

@@ rtl/sfr_back.sv @@
// Back part: unrolls one job at a time into single result bytes.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_back import sfr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sfr_job_t       job_i,
  input  sfr_q_status_t  q_status_i,
  output logic           job_pop_o,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [ByteW-1:0] out_char_o,
  output logic           run_last_o,
  output logic           text_end_o
);

  sfr_job_t        cur_q, cur_d;
  logic            cur_valid_q, cur_valid_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            last_byte, take, load;

  always_comb begin
    last_byte = (idx_q == cur_q.nm1);
    take      = cur_valid_q && pop_i;
    load      = !cur_valid_q || (take && last_byte);
    job_pop_o = load && !q_status_i.empty;

    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (load) begin
      cur_d       = job_i;
      cur_valid_d = !q_status_i.empty;
      idx_d       = '0;
    end else if (take) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign empty_o    = !cur_valid_q;
  assign out_char_o = cur_q.bytes[{idx_q, 3'b000} +: ByteW];
  assign run_last_o = last_byte;
  assign text_end_o = last_byte && cur_q.last;

endmodule

@@ rtl/stream_find_replace.sv @@
// Top level of the stream find/replace block.
// Depends on sfr_pkg, sfr_front, sfr_job_fifo, sfr_back and the assertion header.
`timescale 1ns / 1ps
`include "stream_find_replace_assert.svh"

// Usage:
// - Input side looks like a queue: drive in_char_i/in_last_i with push high;
//   a byte transfers on a clock edge where push is high and full is low.
// - Result side looks like a queue: while empty is low, out_char_o, run_last_o
//   and text_end_o show the oldest result; it transfers when pop is high.
// - Configure pattern and replacement through cfg_we_i/cfg_idx_i/cfg_data_i
//   only while no text is in flight; writes take effect at the next edge.
// - Each accepted byte yields zero to eight result bytes. The first result of
//   a byte passes through the job queue and then the back part's current-job
//   register before it shows on out_char_o.
// - Throughput: one input byte per cycle while full is low; the back part drains
//   one result byte per cycle while pop is high, so a replacement burst of N
//   bytes holds the input off once the two-entry job queue has filled.
// - When the receiver stalls, the current result holds and the job queue
//   fills; full then rises and the sender waits.
// - Reset clears the match window, empties the queue, sets both lengths to
//   one and both byte registers to zero.
module stream_find_replace import sfr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push,
  output logic                full,
  input  logic [ByteW-1:0]    in_char_i,
  input  logic                in_last_i,
  output logic                empty,
  input  logic                pop,
  output logic [ByteW-1:0]    out_char_o,
  output logic                run_last_o,
  output logic                text_end_o
);

  logic          accept;
  logic          jq_push, jq_pop;
  sfr_job_t      jq_wdata, jq_rdata;
  sfr_q_status_t jq_status;

  // Transfer an input byte only when the job queue has room.
  assign full   = jq_status.full;
  assign accept = push && !jq_status.full;

  sfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .in_char_i  (in_char_i),
    .in_last_i  (in_last_i),
    .job_push_o (jq_push),
    .job_o      (jq_wdata)
  );

  sfr_job_fifo u_job_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (jq_push),
    .data_i   (jq_wdata),
    .pop_i    (jq_pop),
    .data_o   (jq_rdata),
    .status_o (jq_status)
  );

  sfr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (jq_rdata),
    .q_status_i (jq_status),
    .job_pop_o  (jq_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_char_o (out_char_o),
    .run_last_o (run_last_o),
    .text_end_o (text_end_o)
  );

  `SFR_ASSERT_IMPLY(a_no_overflow, jq_push, !jq_status.full, "job pushed into full queue")
  `SFR_ASSERT_IMPLY(a_no_underflow, jq_pop, !jq_status.empty, "job popped from empty queue")
  `SFR_ASSERT_IMPLY(a_last_emits, accept && in_last_i, jq_push, "last byte produced no job")
  `SFR_ASSERT(a_stall_holds, (!empty && !pop) |=> !empty, "stalled result vanished")

endmodule
